// File: hdl/bc_pkg.sv
package bc_pkg;

    localparam int RAW_W    = 24;
    localparam int CAL_W    = 16;
    localparam int DT_W     = 25;
    localparam int PROD1_W  = 42;
    localparam int DD_W     = 50;
    localparam int Q_W      = 18;
    localparam int T2_W     = 17;
    localparam int TEMP_W   = 20;
    localparam int QQ_W     = 36;
    localparam int SQ_W     = 35;
    localparam int FIVE_W   = 37;
    localparam int OFF_W    = 40;
    localparam int SENS_W   = 38;
    localparam int SPLIT    = 19;
    localparam int PLO_W    = 43;
    localparam int PHI_W    = 44;
    localparam int PROD_W   = 63;
    localparam int DIFF_W   = 43;
    localparam int OUT_W    = 32;
    localparam int STAGES   = 9;

    localparam int TEMP_SHIFT  = 23;
    localparam int OFF_SHIFT   = 7;
    localparam int SENS_SHIFT  = 8;
    localparam int T2_SHIFT    = 31;
    localparam int PRESS_SHIFT = 21;
    localparam int DIV_SHIFT   = 15;

    localparam logic signed [TEMP_W-1:0] TEMP_BASE = 20'sd2000;

    typedef enum logic [2:0] {
        CAL_PRESSURE_SENSITIVITY  = 3'd0,
        CAL_PRESSURE_OFFSET       = 3'd1,
        CAL_SENS_TEMP_COEFF       = 3'd2,
        CAL_OFFSET_TEMP_COEFF     = 3'd3,
        CAL_REFERENCE_TEMPERATURE = 3'd4,
        CAL_TEMP_SLOPE            = 3'd5
    } cal_idx_t;

    typedef struct packed {
        logic [CAL_W-1:0] pressure_sensitivity;
        logic [CAL_W-1:0] pressure_offset;
        logic [CAL_W-1:0] sens_temp_coeff;
        logic [CAL_W-1:0] offset_temp_coeff;
        logic [CAL_W-1:0] reference_temperature;
        logic [CAL_W-1:0] temp_slope;
    } cal_t;

    // First-order terms, before the low-temperature correction.
    typedef struct packed {
        logic signed [Q_W-1:0]    q;
        logic [T2_W-1:0]          t2;
        logic signed [OFF_W-1:0]  off1;
        logic signed [SENS_W-1:0] sens1;
        logic [RAW_W-1:0]         rp;
    } front_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic                     low;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
        logic [RAW_W-1:0]         rp;
    } corr_t;

    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/bc_front.sv
module bc_front (
    input  logic                             clk,
    input  logic [2:0]                       en,
    input  bc_pkg::cal_t                     cal,
    input  logic [bc_pkg::RAW_W-1:0]         raw_temperature,
    input  logic [bc_pkg::RAW_W-1:0]         raw_pressure,
    output bc_pkg::front_t                   front
);

    localparam int DTW  = bc_pkg::DT_W;
    localparam int PW   = bc_pkg::PROD1_W;
    localparam int DDW  = bc_pkg::DD_W;
    localparam int OW   = bc_pkg::OFF_W;
    localparam int SW   = bc_pkg::SENS_W;
    localparam int TS   = bc_pkg::TEMP_SHIFT;
    localparam int QW   = bc_pkg::Q_W;
    localparam int T2S  = bc_pkg::T2_SHIFT;
    localparam int T2W  = bc_pkg::T2_W;
    localparam int TRUNC_BIAS = (1 << TS) - 1;

    logic signed [DTW-1:0] dt_reg, dt_next;
    logic [bc_pkg::RAW_W-1:0] rp1_reg, rp2_reg;

    logic signed [PW-1:0] mt_reg, mt_next;
    logic signed [PW-1:0] mo_reg, mo_next;
    logic signed [PW-1:0] ms_reg, ms_next;
    logic signed [DDW-1:0] dd;
    logic [T2W-1:0] t2_reg, t2_next;

    logic signed [16:0] slope_s, offc_s, sensc_s;
    logic signed [PW-1:0] biased;
    bc_pkg::front_t front_reg, front_next;

    assign dt_next = $signed({1'b0, raw_temperature})
                   - $signed({1'b0, cal.reference_temperature, 8'h00});

    assign slope_s = $signed({1'b0, cal.temp_slope});
    assign offc_s  = $signed({1'b0, cal.offset_temp_coeff});
    assign sensc_s = $signed({1'b0, cal.sens_temp_coeff});

    assign mt_next = PW'(dt_reg) * PW'(slope_s);
    assign mo_next = PW'(dt_reg) * PW'(offc_s);
    assign ms_next = PW'(dt_reg) * PW'(sensc_s);
    assign dd      = DDW'(dt_reg) * DDW'(dt_reg);
    // The square is never negative and stays below 2^48, so the shift is a slice.
    assign t2_next = dd[T2S+T2W-1:T2S];

    // Division by 2^23 truncates toward zero: negative values get a bias first.
    assign biased = mt_reg + (mt_reg[PW-1] ? PW'(TRUNC_BIAS) : PW'(0));

    always_comb
    begin
        front_next.q     = $signed(biased[TS+QW-1:TS]);
        front_next.t2    = t2_reg;
        front_next.off1  = OW'($signed({1'b0, cal.pressure_offset, 16'h0000}))
                         + OW'(mo_reg >>> bc_pkg::OFF_SHIFT);
        front_next.sens1 = SW'($signed({1'b0, cal.pressure_sensitivity, 15'h0000}))
                         + SW'(ms_reg >>> bc_pkg::SENS_SHIFT);
        front_next.rp    = rp2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dt_reg  <= dt_next;
            rp1_reg <= raw_pressure;
        end
        if (en[1])
        begin
            mt_reg  <= mt_next;
            mo_reg  <= mo_next;
            ms_reg  <= ms_next;
            t2_reg  <= t2_next;
            rp2_reg <= rp1_reg;
        end
        if (en[2])
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

// File: hdl/bc_corr.sv
module bc_corr (
    input  logic           clk,
    input  logic [1:0]     en,
    input  bc_pkg::front_t front,
    output bc_pkg::corr_t  corr
);

    localparam int QQW = bc_pkg::QQ_W;
    localparam int SQW = bc_pkg::SQ_W;
    localparam int FW  = bc_pkg::FIVE_W;
    localparam int TW  = bc_pkg::TEMP_W;
    localparam int OW  = bc_pkg::OFF_W;
    localparam int SW  = bc_pkg::SENS_W;

    logic signed [QQW-1:0] qq;
    logic [SQW-1:0] sq_reg, sq_next;
    logic signed [TW-1:0] temp_reg, temp_next;
    logic low_reg, low_next;
    logic signed [OW-1:0] off1_reg;
    logic signed [SW-1:0] sens1_reg;
    logic [bc_pkg::RAW_W-1:0] rp_reg;

    logic [FW-1:0] five;
    bc_pkg::corr_t corr_reg, corr_next;

    assign qq       = QQW'(front.q) * QQW'(front.q);
    assign sq_next  = qq[SQW-1:0];
    assign low_next = front.q[bc_pkg::Q_W-1];

    // The second-order temperature term only applies below the base temperature.
    assign temp_next = bc_pkg::TEMP_BASE + TW'(front.q)
                     - (low_next ? TW'($signed({3'b000, front.t2})) : TW'(0));

    assign five = FW'(sq_reg) + {sq_reg, 2'b00};

    always_comb
    begin
        corr_next.temp = temp_reg;
        corr_next.low  = low_reg;
        corr_next.off  = off1_reg
                       - (low_reg ? OW'($signed({1'b0, five[FW-1:1]})) : OW'(0));
        corr_next.sens = sens1_reg
                       - (low_reg ? SW'($signed({1'b0, five[FW-1:2]})) : SW'(0));
        corr_next.rp   = rp_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sq_reg    <= sq_next;
            temp_reg  <= temp_next;
            low_reg   <= low_next;
            off1_reg  <= front.off1;
            sens1_reg <= front.sens1;
            rp_reg    <= front.rp;
        end
        if (en[1])
        begin
            corr_reg <= corr_next;
        end
    end

    assign corr = corr_reg;

endmodule

// File: hdl/bc_press.sv
module bc_press (
    input  logic                              clk,
    input  logic [3:0]                        en,
    input  bc_pkg::corr_t                     corr,
    output logic signed [bc_pkg::OUT_W-1:0]   temperature_centi,
    output logic signed [bc_pkg::OUT_W-1:0]   pressure_pa,
    output logic                              low_temp_corrected
);

    localparam int PLW = bc_pkg::PLO_W;
    localparam int PHW = bc_pkg::PHI_W;
    localparam int PRW = bc_pkg::PROD_W;
    localparam int DW  = bc_pkg::DIFF_W;
    localparam int SW  = bc_pkg::SENS_W;
    localparam int SP  = bc_pkg::SPLIT;
    localparam int TW  = bc_pkg::TEMP_W;
    localparam int OW  = bc_pkg::OFF_W;
    localparam int DIV_BIAS = (1 << bc_pkg::DIV_SHIFT) - 1;

    // The raw-pressure product is split on sensitivity into a low unsigned
    // part and a high signed part, recombined one stage later.
    logic [PLW-1:0] plo_reg, plo_next;
    logic signed [PHW-1:0] phi_reg, phi_next;
    logic signed [PRW-1:0] prod_reg, prod_next;
    logic signed [DW-1:0] diff_reg, diff_next;
    logic signed [DW-1:0] biased, quot;

    logic signed [TW-1:0] temp6_reg, temp7_reg, temp8_reg;
    logic low6_reg, low7_reg, low8_reg;
    logic signed [OW-1:0] off6_reg, off7_reg;

    logic signed [bc_pkg::OUT_W-1:0] temperature_centi_reg, pressure_pa_reg;
    logic low_temp_corrected_reg;

    assign plo_next  = PLW'(corr.rp) * PLW'(corr.sens[SP-1:0]);
    assign phi_next  = PHW'($signed({1'b0, corr.rp})) * PHW'($signed(corr.sens[SW-1:SP]));
    assign prod_next = (PRW'(phi_reg) <<< SP) + PRW'($signed({1'b0, plo_reg}));
    assign diff_next = DW'(prod_reg >>> bc_pkg::PRESS_SHIFT) - DW'(off7_reg);

    // Division by 2^15 truncates toward zero.
    assign biased = diff_reg + (diff_reg[DW-1] ? DW'(DIV_BIAS) : DW'(0));
    assign quot   = biased >>> bc_pkg::DIV_SHIFT;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            temp6_reg <= corr.temp;
            low6_reg  <= corr.low;
            off6_reg  <= corr.off;
        end
        if (en[1])
        begin
            prod_reg  <= prod_next;
            temp7_reg <= temp6_reg;
            low7_reg  <= low6_reg;
            off7_reg  <= off6_reg;
        end
        if (en[2])
        begin
            diff_reg  <= diff_next;
            temp8_reg <= temp7_reg;
            low8_reg  <= low7_reg;
        end
        if (en[3])
        begin
            temperature_centi_reg  <= bc_pkg::sat32(64'(temp8_reg));
            pressure_pa_reg        <= bc_pkg::sat32(64'(quot));
            low_temp_corrected_reg <= low8_reg;
        end
    end

    assign temperature_centi  = temperature_centi_reg;
    assign pressure_pa        = pressure_pa_reg;
    assign low_temp_corrected = low_temp_corrected_reg;

endmodule

// File: hdl/barometer_compensation.sv
// Compensates raw 24-bit temperature and pressure conversions with six 16-bit
// calibration words and returns temperature in hundredths of a degree and
// pressure in pascals, with the second-order correction below 20.00 degrees.
// The block takes one input transfer per clock while in_stall is low and
// returns one result per input. The nine pipeline stages are, in order,
// the temperature difference, the three calibration products together with
// the square of the difference, the first-order terms, the squared
// temperature deviation, the correction, the two-part pressure product, its
// recombination, the offset subtraction and the final division with
// saturation. Stalls only back up as far as the pipeline is full, so empty
// stages keep filling while a result waits.
// Calibration writes take effect at once and belong between items.
module barometer_compensation (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [2:0]                        cfg_index,
    input  logic [bc_pkg::CAL_W-1:0]          cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bc_pkg::RAW_W-1:0]          raw_temperature,
    input  logic [bc_pkg::RAW_W-1:0]          raw_pressure,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [bc_pkg::OUT_W-1:0]   temperature_centi,
    output logic signed [bc_pkg::OUT_W-1:0]   pressure_pa,
    output logic                              low_temp_corrected
);

    localparam int NS = bc_pkg::STAGES;

    bc_pkg::cal_t cal_reg;
    logic [NS-1:0] valid_reg, valid_next;
    logic [NS-1:0] en;

    bc_pkg::front_t front;
    bc_pkg::corr_t  corr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bc_pkg::CAL_PRESSURE_SENSITIVITY:  cal_reg.pressure_sensitivity  <= cfg_data;
                bc_pkg::CAL_PRESSURE_OFFSET:       cal_reg.pressure_offset       <= cfg_data;
                bc_pkg::CAL_SENS_TEMP_COEFF:       cal_reg.sens_temp_coeff       <= cfg_data;
                bc_pkg::CAL_OFFSET_TEMP_COEFF:     cal_reg.offset_temp_coeff     <= cfg_data;
                bc_pkg::CAL_REFERENCE_TEMPERATURE: cal_reg.reference_temperature <= cfg_data;
                bc_pkg::CAL_TEMP_SLOPE:            cal_reg.temp_slope            <= cfg_data;
                default:                           cal_reg <= cal_reg;
            endcase
        end
    end

    // A stage loads when it is empty or when the stage after it loads too.
    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = valid_reg[NS-1];

    bc_front u_front (
        .clk             (clk),
        .en              (en[2:0]),
        .cal             (cal_reg),
        .raw_temperature (raw_temperature),
        .raw_pressure    (raw_pressure),
        .front           (front)
    );

    bc_corr u_corr (
        .clk   (clk),
        .en    (en[4:3]),
        .front (front),
        .corr  (corr)
    );

    bc_press u_press (
        .clk                (clk),
        .en                 (en[8:5]),
        .corr               (corr),
        .temperature_centi  (temperature_centi),
        .pressure_pa        (pressure_pa),
        .low_temp_corrected (low_temp_corrected)
    );

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&valid_reg))
        else $error("input stalled while the pipeline has an empty stage");

    a_no_stall_without_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while the output is free");

    a_low_flag_matches_temp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (low_temp_corrected == (temperature_centi < 32'sd2000)))
        else $error("correction flag disagrees with the compensated temperature");
`endif

endmodule
